/* rtl/dbdm_pkg.sv */
// Shared constants, codes and glyph table for the debounced digit matrix display.
`timescale 1ns / 1ps
package dbdm_pkg;

    localparam int PIXEL_COUNT = 25;
    localparam int GRID        = 5;
    localparam int SLOT_W      = $clog2(PIXEL_COUNT);
    localparam int POS_W       = $clog2(GRID);
    localparam int DIGIT_W     = 4;
    localparam int TIME_W      = 32;
    localparam int COLOR_W     = 24;
    localparam int REQ_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(9);

    // request codes
    localparam logic [REQ_W-1:0] REQ_INC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEC = 2'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR    = 2'd1;

    localparam logic [TIME_W-1:0]  DEBOUNCE_RESET = TIME_W'(200000);
    localparam logic [COLOR_W-1:0] COLOR_RESET    = COLOR_W'(200);

    typedef logic [GRID*GRID-1:0] t_glyph;

    typedef struct packed {
        logic               start;
        logic [DIGIT_W-1:0] digit;
    } t_frame_cmd;

    // Glyph rows packed top row in the low bits; column c of a row is bit c.
    function automatic t_glyph glyph_bits(input logic [DIGIT_W-1:0] digit);
        t_glyph g;
        unique case (digit)
            4'd0:    g = {5'h0E, 5'h0A, 5'h0A, 5'h0A, 5'h0E};
            4'd1:    g = {5'h08, 5'h08, 5'h08, 5'h08, 5'h08};
            4'd2:    g = {5'h0E, 5'h02, 5'h0E, 5'h08, 5'h0E};
            4'd3:    g = {5'h0E, 5'h08, 5'h0E, 5'h08, 5'h0E};
            4'd4:    g = {5'h08, 5'h08, 5'h0E, 5'h0A, 5'h0A};
            4'd5:    g = {5'h0E, 5'h08, 5'h0E, 5'h02, 5'h0E};
            4'd6:    g = {5'h0E, 5'h0A, 5'h0E, 5'h02, 5'h0E};
            4'd7:    g = {5'h08, 5'h08, 5'h08, 5'h08, 5'h0E};
            4'd8:    g = {5'h0E, 5'h0A, 5'h0E, 5'h0A, 5'h0E};
            4'd9:    g = {5'h0E, 5'h08, 5'h0E, 5'h0A, 5'h0E};
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

/* rtl/dbdm_frame.sv */
// Frame streamer: walks the 25 send slots in serpentine order and emits pixel beats.
`timescale 1ns / 1ps
module dbdm_frame (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dbdm_pkg::t_frame_cmd           i_cmd,
    input  logic [dbdm_pkg::COLOR_W-1:0]   i_color,
    output logic                           o_busy,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [dbdm_pkg::COLOR_W-1:0]   o_pixel_color,
    output logic [dbdm_pkg::SLOT_W-1:0]    o_pixel_slot,
    output logic                           o_last_pixel
);

    localparam logic [dbdm_pkg::SLOT_W-1:0] LastSlot =
        dbdm_pkg::SLOT_W'(dbdm_pkg::PIXEL_COUNT - 1);
    localparam logic [dbdm_pkg::POS_W-1:0]  LastPos  =
        dbdm_pkg::POS_W'(dbdm_pkg::GRID - 1);

    logic                           r_busy;
    logic [dbdm_pkg::SLOT_W-1:0]    r_slot;
    logic [dbdm_pkg::POS_W-1:0]     r_row;
    logic [dbdm_pkg::POS_W-1:0]     r_col;
    logic [dbdm_pkg::DIGIT_W-1:0]   r_digit;

    logic                           beat;
    dbdm_pkg::t_glyph               glyph;
    logic [dbdm_pkg::POS_W-1:0]     glyph_row;
    logic [dbdm_pkg::POS_W-1:0]     glyph_col;
    logic [dbdm_pkg::SLOT_W-1:0]    bit_idx;

    assign beat = r_busy && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_slot <= '0;
            r_row  <= '0;
            r_col  <= '0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
            r_slot <= '0;
            r_row  <= '0;
            r_col  <= '0;
        end else if (beat) begin
            if (r_slot == LastSlot) begin
                r_busy <= 1'b0;
            end
            r_slot <= r_slot + 1'b1;
            if (r_col == LastPos) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_digit <= i_cmd.digit;
        end
    end

    // Send order runs bottom row first; even send rows read the glyph row mirrored.
    always_comb begin
        glyph     = dbdm_pkg::glyph_bits(r_digit);
        glyph_row = LastPos - r_row;
        glyph_col = r_row[0] ? r_col : (LastPos - r_col);
        bit_idx   = dbdm_pkg::SLOT_W'(glyph_row) * dbdm_pkg::SLOT_W'(dbdm_pkg::GRID)
                  + dbdm_pkg::SLOT_W'(glyph_col);
    end

    assign o_busy        = r_busy;
    assign o_out_valid   = r_busy;
    assign o_pixel_color = glyph[bit_idx] ? i_color : '0;
    assign o_pixel_slot  = r_slot;
    assign o_last_pixel  = (r_slot == LastSlot);

endmodule

/* rtl/debounced_digit_matrix_display_core.sv */
// Top level: debounce filter, digit state memory and frame streamer.
`timescale 1ns / 1ps
// Usage
//   Input channel (i_in_valid / o_in_stall): one beat is a button event with
//   i_req_type (0 up, 1 down, 2 or 3 redisplay) and a microsecond stamp.
//   The event passes when (stamp - last passed stamp) mod 2^32 exceeds
//   the debounce register; a passed event steps the digit (up/down) and sends a frame.
//   Output channel (o_out_valid / i_out_stall): 25 pixel beats per frame,
//   slot 0..24, o_last_pixel on slot 24, color or zero from the 5x5 glyph.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 is the
//   debounce threshold, index 1 the lit GRB color; other indexes are dropped.
//   The event payload and the memory read are registered on the event beat; the
//   check state starts the frame, and a filtered event frees the input after it.
//   The input stalls until the frame is sent and the FSM is back in idle; the
//   rate is set by the single pixel beat per cycle, held while the output stalls.
//   The digit and last stamp live in a one-entry synchronous memory read on
//   the event beat and written back in the next cycle on a passed check; only
//   one event is in flight, so no forwarding is needed.
//   Reset: digit and stamp read as zero until the first write, registers
//   take their defaults. A stall on the output holds the pixel beat as is.
module debounced_digit_matrix_display_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [dbdm_pkg::REQ_W-1:0]        i_req_type,
    input  logic [dbdm_pkg::TIME_W-1:0]       i_event_time,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [dbdm_pkg::COLOR_W-1:0]      o_pixel_color,
    output logic [dbdm_pkg::SLOT_W-1:0]       o_pixel_slot,
    output logic                              o_last_pixel,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dbdm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dbdm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_SEND  = 2'd2;

    localparam int MemW = dbdm_pkg::DIGIT_W + dbdm_pkg::TIME_W;

    logic [1:0]                      r_fsm, n_fsm;
    logic [dbdm_pkg::TIME_W-1:0]     r_debounce;
    logic [dbdm_pkg::COLOR_W-1:0]    r_color;
    logic [dbdm_pkg::REQ_W-1:0]      r_req;
    logic [dbdm_pkg::TIME_W-1:0]     r_time;

    // one-entry state memory: {digit, last passed stamp}
    logic [MemW-1:0]                 r_state_mem [0:0];
    logic                            r_mem_vld;
    logic [MemW-1:0]                 r_rd_q;
    logic                            r_rd_vld;

    logic                            in_beat;
    logic                            pass;
    logic                            mem_we;
    logic [dbdm_pkg::DIGIT_W-1:0]    cur_digit;
    logic [dbdm_pkg::DIGIT_W-1:0]    n_digit;
    logic [dbdm_pkg::TIME_W-1:0]     cur_time;
    logic [dbdm_pkg::TIME_W-1:0]     gap;
    dbdm_pkg::t_frame_cmd            frame_cmd;
    logic                            frame_busy;

    assign in_beat     = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_fsm != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= dbdm_pkg::DEBOUNCE_RESET;
            r_color    <= dbdm_pkg::COLOR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                dbdm_pkg::REG_DEBOUNCE: r_debounce <= i_cfg_data;
                dbdm_pkg::REG_COLOR:    r_color    <= i_cfg_data[dbdm_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // hold the event payload for the check cycle
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_req  <= i_req_type;
            r_time <= i_event_time;
        end
    end

    // state memory: read on the event beat, write back on a passed check
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_state_mem[0] <= {n_digit, r_time};
        end
        if (in_beat) begin
            r_rd_q <= r_state_mem[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (mem_we) begin
                r_mem_vld <= 1'b1;
            end
            if (in_beat) begin
                r_rd_vld <= r_mem_vld;
            end
        end
    end

    // unwritten memory reads as the reset state
    always_comb begin
        cur_digit = r_rd_vld ? r_rd_q[MemW-1 -: dbdm_pkg::DIGIT_W] : '0;
        cur_time  = r_rd_vld ? r_rd_q[dbdm_pkg::TIME_W-1:0] : '0;
        gap       = r_time - cur_time;
        pass      = (gap > r_debounce);
        case (r_req)
            dbdm_pkg::REQ_INC:
                n_digit = (cur_digit >= dbdm_pkg::DIGIT_MAX) ? '0 : cur_digit + 1'b1;
            dbdm_pkg::REQ_DEC:
                n_digit = (cur_digit == '0 || cur_digit > dbdm_pkg::DIGIT_MAX)
                        ? dbdm_pkg::DIGIT_MAX : cur_digit - 1'b1;
            default:
                n_digit = cur_digit;
        endcase
    end

    assign mem_we    = (r_fsm == ST_CHECK) && pass;
    assign frame_cmd = '{start: mem_we, digit: n_digit};

    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            ST_IDLE:  if (in_beat) n_fsm = ST_CHECK;
            ST_CHECK: n_fsm = pass ? ST_SEND : ST_IDLE;
            ST_SEND:  if (!frame_busy) n_fsm = ST_IDLE;
            default:  n_fsm = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= ST_IDLE;
        end else begin
            r_fsm <= n_fsm;
        end
    end

    dbdm_frame u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (frame_cmd),
        .i_color       (r_color),
        .o_busy        (frame_busy),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_color (o_pixel_color),
        .o_pixel_slot  (o_pixel_slot),
        .o_last_pixel  (o_last_pixel)
    );

    // pixels only while a frame is being sent
    a_out_in_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_fsm == ST_SEND))
        else $error("pixel beat outside frame send");

    // stored digit stays within 0..9
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mem_vld |-> (r_state_mem[0][MemW-1 -: dbdm_pkg::DIGIT_W] <= dbdm_pkg::DIGIT_MAX))
        else $error("stored digit out of range");

    // slots advance by one per taken beat
    a_slot_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_pixel)
            |=> (o_out_valid && o_pixel_slot == $past(o_pixel_slot) + 1'b1))
        else $error("pixel slot skipped or repeated");

    // frame ends after the last pixel is taken
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_pixel) |=> !o_out_valid)
        else $error("pixel beat after last pixel");

endmodule

/* verif/tb_debounced_digit_matrix_display_core.sv */
// Self-checking testbench for the debounced digit matrix display core.
`timescale 1ns / 1ps
module tb_debounced_digit_matrix_display_core;
    import dbdm_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 3;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_COUNT    = 5;
    localparam int PHASE_ITEMS    = 17;
    localparam int HOLD_OFF       = 200;

    // request codes the package leaves unnamed: both only redisplay
    localparam logic [REQ_W-1:0] REQ_SHOW  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

    // register indexes past the list: writes are dropped by the block
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_BURSTY} t_stall_mode;

    typedef struct packed {
        logic [COLOR_W-1:0] grb;
        logic [SLOT_W-1:0]  slot;
        logic               last;
    } t_pixel_beat;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_in_valid    = 1'b0;
    logic                   o_in_stall;
    logic [REQ_W-1:0]       i_req_type    = '0;
    logic [TIME_W-1:0]      i_event_time  = '0;
    logic                   o_out_valid;
    logic                   i_out_stall   = 1'b0;
    logic [COLOR_W-1:0]     o_pixel_color;
    logic [SLOT_W-1:0]      o_pixel_slot;
    logic                   o_last_pixel;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    // predicted state of the block
    logic [TIME_W-1:0]  pred_debounce_us = DEBOUNCE_RESET;
    logic [COLOR_W-1:0] pred_color       = COLOR_RESET;
    logic [DIGIT_W-1:0] pred_digit       = '0;
    logic [TIME_W-1:0]  pred_stamp       = '0;

    t_pixel_beat pending_pixels[$];
    t_pixel_beat head_beat;

    int unsigned err_count       = 0;
    int unsigned events_sent     = 0;
    int unsigned events_filtered = 0;
    int unsigned frames_expected = 0;
    int unsigned beats_checked   = 0;
    int unsigned cfg_writes      = 0;
    int unsigned quiet_cycles    = 0;
    logic [9:0]  digits_shown    = '0;

    // receiver stall control
    t_stall_mode stall_mode   = STALL_NONE;
    int unsigned hold_request = 0;
    int unsigned hold_left    = 0;
    int unsigned run_left     = 0;
    logic        run_stall    = 1'b0;

    debounced_digit_matrix_display_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_event_time  (i_event_time),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_color (o_pixel_color),
        .o_pixel_slot  (o_pixel_slot),
        .o_last_pixel  (o_last_pixel),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Glyph rows, top row in the high bits; column c of a row is bit c.
    function automatic logic [GRID*GRID-1:0] glyph_rows_of(input logic [DIGIT_W-1:0] digit);
        case (digit)
            4'd0:    return {5'h0E, 5'h0A, 5'h0A, 5'h0A, 5'h0E};
            4'd1:    return {5'h08, 5'h08, 5'h08, 5'h08, 5'h08};
            4'd2:    return {5'h0E, 5'h08, 5'h0E, 5'h02, 5'h0E};
            4'd3:    return {5'h0E, 5'h08, 5'h0E, 5'h08, 5'h0E};
            4'd4:    return {5'h0A, 5'h0A, 5'h0E, 5'h08, 5'h08};
            4'd5:    return {5'h0E, 5'h02, 5'h0E, 5'h08, 5'h0E};
            4'd6:    return {5'h0E, 5'h02, 5'h0E, 5'h0A, 5'h0E};
            4'd7:    return {5'h0E, 5'h08, 5'h08, 5'h08, 5'h08};
            4'd8:    return {5'h0E, 5'h0A, 5'h0E, 5'h0A, 5'h0E};
            4'd9:    return {5'h0E, 5'h0A, 5'h0E, 5'h08, 5'h0E};
            default: return '0;
        endcase
    endfunction

    // Send slots run serpentine over the grid and then back to front.
    function automatic logic pixel_lit(input logic [DIGIT_W-1:0] digit, input int unsigned slot);
        int unsigned col;
        int unsigned row;
        int unsigned lin;
        int unsigned grid_idx;
        logic [GRID*GRID-1:0] rows;
        logic [GRID-1:0]      bits;
        col      = slot % GRID;
        row      = slot / GRID;
        lin      = (row % 2 == 0) ? row * GRID + col : row * GRID + (GRID - 1 - col);
        grid_idx = GRID * GRID - 1 - lin;
        rows     = glyph_rows_of(digit);
        bits     = rows[(GRID*GRID-1) - GRID*(grid_idx/GRID) -: GRID];
        return bits[grid_idx % GRID];
    endfunction

    // Apply one accepted button event; queue its frame if it passes the filter.
    task automatic predict_button_event(input logic [REQ_W-1:0] req,
                                        input logic [TIME_W-1:0] stamp);
        logic [TIME_W-1:0] since;
        t_pixel_beat       beat;
        since = stamp - pred_stamp;
        if (since <= pred_debounce_us) begin
            events_filtered++;
            return;
        end
        pred_stamp = stamp;
        case (req)
            REQ_INC: pred_digit = (pred_digit >= DIGIT_MAX) ? '0 : pred_digit + 1'b1;
            REQ_DEC: pred_digit = (pred_digit == '0 || pred_digit > DIGIT_MAX) ?
                                  DIGIT_MAX : pred_digit - 1'b1;
            default: ;
        endcase
        digits_shown[pred_digit] = 1'b1;
        frames_expected++;
        for (int s = 0; s < PIXEL_COUNT; s++) begin
            beat.grb  = pixel_lit(pred_digit, s) ? pred_color : '0;
            beat.slot = SLOT_W'(s);
            beat.last = (s == PIXEL_COUNT - 1);
            pending_pixels.push_back(beat);
        end
    endtask

    // Offer one event beat and hold it until the block takes it.
    task automatic send_event(input logic [REQ_W-1:0] req, input logic [TIME_W-1:0] stamp);
        @(negedge i_clk);
        i_in_valid   = 1'b1;
        i_req_type   = req;
        i_event_time = stamp;
        do @(posedge i_clk); while (o_in_stall);
        events_sent++;
        predict_button_event(req, stamp);
    endtask

    task automatic idle_input(input int unsigned cycles);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Drop valid, drain every expected pixel, then cover the filter latency.
    task automatic wait_block_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_writes++;
        case (idx)
            REG_DEBOUNCE: pred_debounce_us = data;
            REG_COLOR:    pred_color       = data[COLOR_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [REQ_W-1:0] pick_request();
        int unsigned pick;
        pick = $urandom_range(9, 0);
        if (pick < 4) return REQ_INC;
        if (pick < 8) return REQ_DEC;
        if (pick == 8) return REQ_SHOW;
        return REQ_SPARE;
    endfunction

    // Mostly stamps that pass the filter, some right at the threshold, some inside it.
    function automatic logic [TIME_W-1:0] pick_stamp();
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] near_max;
        int unsigned       pick;
        span     = 32'hFFFF_FFFF - pred_debounce_us;
        near_max = (span - 1 < 32'd5000) ? span - 1 : 32'd5000;
        pick     = $urandom_range(19, 0);
        if (span == 0 || pick < 4)
            gap = (pick == 0) ? pred_debounce_us : $urandom_range(pred_debounce_us, 0);
        else if (pick < 7)
            gap = pred_debounce_us + 1;
        else if (pick < 16)
            gap = pred_debounce_us + 1 + $urandom_range(near_max, 0);
        else
            gap = pred_debounce_us + 1 + ($urandom % span);
        return pred_stamp + gap;
    endfunction

    // Reset defaults: threshold boundary, both wraps of the digit, redisplay codes.
    task automatic test_directed_defaults();
        send_event(REQ_INC, 32'd200000);
        send_event(REQ_INC, 32'd200001);
        send_event(REQ_DEC, pred_stamp + 32'd100);
        send_event(REQ_DEC, pred_stamp + 32'd200001);
        send_event(REQ_DEC, pred_stamp + 32'd200001);
        send_event(REQ_INC, pred_stamp + 32'd300000);
        send_event(REQ_SHOW, pred_stamp + 32'd250000);
        send_event(REQ_SPARE, pred_stamp + 32'd200001);
    endtask

    // Register extremes, stamp wrap, dropped register indexes.
    task automatic test_config_extremes();
        wait_block_idle();
        write_register(REG_DEBOUNCE, 32'd0);
        write_register(REG_COLOR, 32'h00FF_FFFF);
        send_event(REQ_INC, pred_stamp);
        send_event(REQ_INC, pred_stamp + 32'd1);
        send_event(REQ_DEC, 32'hFFFF_FFFF);
        send_event(REQ_INC, 32'h0000_0000);

        wait_block_idle();
        write_register(REG_COLOR, 32'd0);
        send_event(REQ_SHOW, 32'd5);

        wait_block_idle();
        write_register(REG_DEBOUNCE, 32'hFFFF_FFFF);
        send_event(REQ_INC, 32'h0000_0000);
        send_event(REQ_DEC, 32'hFFFF_FFFF);
        send_event(REQ_SHOW, 32'h8000_0000);

        wait_block_idle();
        write_register(REG_COLOR, 32'hFF12_3456);
        write_register(REG_DEBOUNCE, 32'd100);
        write_register(REG_SPARE_A, 32'hFFFF_FFFF);
        write_register(REG_SPARE_B, $urandom);
        send_event(REQ_INC, pred_stamp + 32'd100);
        send_event(REQ_INC, pred_stamp + 32'd101);
    endtask

    // Long receiver hold-off while events keep coming, then a full drain.
    task automatic test_backpressure();
        wait_block_idle();
        write_register(REG_DEBOUNCE, 32'd10);
        stall_mode   = STALL_NONE;
        hold_request = HOLD_OFF;
        repeat (4) send_event(pick_request(), pred_stamp + 32'd11 + $urandom_range(50, 0));
        wait_block_idle();
        repeat (2) send_event(pick_request(), pred_stamp + 32'd11 + $urandom_range(50, 0));
    endtask

    task automatic run_random_phase(input int unsigned items);
        int unsigned burst_left;
        logic        gappy;
        gappy      = ($urandom_range(3, 0) != 0);
        burst_left = $urandom_range(8, 1);
        repeat (items) begin
            send_event(pick_request(), pick_stamp());
            burst_left--;
            if (burst_left == 0) begin
                if (gappy) idle_input($urandom_range(12, 1));
                burst_left = $urandom_range(8, 1);
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] threshold;
        logic [CFG_DATA_W-1:0] color;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            wait_block_idle();
            case ($urandom_range(3, 0))
                0:       threshold = '0;
                3:       threshold = $urandom;
                default: threshold = $urandom_range(2000, 0);
            endcase
            if ($urandom_range(4, 0) == 0)
                color = $urandom_range(1, 0) ? 32'h00FF_FFFF : 32'd0;
            else
                color = $urandom;
            write_register(REG_DEBOUNCE, threshold);
            write_register(REG_COLOR, color);
            stall_mode = t_stall_mode'($urandom_range(2, 0));
            run_random_phase(PHASE_ITEMS);
        end
    endtask

    // Receiver side: hold-off when asked, otherwise the current stall pattern.
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else begin
            case (stall_mode)
                STALL_NONE:  i_out_stall = 1'b0;
                STALL_LIGHT: i_out_stall = ($urandom_range(3, 0) == 0);
                STALL_BURSTY: begin
                    if (run_left == 0) begin
                        run_stall = ($urandom_range(9, 0) < 6);
                        run_left  = $urandom_range(8, 1);
                    end
                    i_out_stall = run_stall;
                    run_left--;
                end
                default: i_out_stall = 1'b0;
            endcase
        end
    end

    // Compare each pixel beat with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                err_count++;
                $display("%0t: unexpected pixel beat color=%h slot=%0d last=%b",
                         $time, o_pixel_color, o_pixel_slot, o_last_pixel);
            end else begin
                head_beat = pending_pixels.pop_front();
                beats_checked++;
                if (o_pixel_color !== head_beat.grb) begin
                    err_count++;
                    $display("%0t: pixel_color expected %h, actual %h (slot %0d)",
                             $time, head_beat.grb, o_pixel_color, head_beat.slot);
                end
                if (o_pixel_slot !== head_beat.slot) begin
                    err_count++;
                    $display("%0t: pixel_slot expected %0d, actual %0d",
                             $time, head_beat.slot, o_pixel_slot);
                end
                if (o_last_pixel !== head_beat.last) begin
                    err_count++;
                    $display("%0t: last_pixel expected %b, actual %b (slot %0d)",
                             $time, head_beat.last, o_last_pixel, head_beat.slot);
                end
            end
        end
    end

    // Watchdog: any beat on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d pixels still pending",
                     $time, quiet_cycles, pending_pixels.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_defaults();
        test_config_extremes();
        test_backpressure();
        test_random_traffic();

        wait_block_idle();
        $display("Run covered %0d events (%0d filtered, %0d frames), %0d pixel beats checked,",
                 events_sent, events_filtered, frames_expected, beats_checked);
        $display("%0d register writes, digits shown (bit per digit) %b",
                 cfg_writes, digits_shown);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
